[sv/cwee_pkg.sv]
package cwee_pkg;

  typedef struct packed {
    logic        vld;
    logic [31:0] sen;
    logic [31:0] ent;
  } entry_t;

  typedef logic [15:0] weight_t;

  localparam int RESULT_LIMIT    = 32;
  localparam int EDGE_CNT_W      = $clog2(RESULT_LIMIT + 1);
  localparam int WEIGHT_ROM_SIZE = 64;

  typedef logic [EDGE_CNT_W-1:0] edge_cnt_t;

  // round(32768 * exp(-d))
  localparam weight_t WEIGHT_ROM [WEIGHT_ROM_SIZE] = '{
    16'd32768, 16'd12055, 16'd4435, 16'd1631, 16'd600, 16'd221, 16'd81, 16'd30,
    16'd11, 16'd4, 16'd1, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0,
    16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
    16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
    16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
    16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
    16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
    16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0
  };

endpackage

[sv/cwee_cell.sv]
module cwee_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              shift_en,
  input  cwee_pkg::entry_t  d_i,
  output cwee_pkg::entry_t  q_o
);

  logic        vld_r;
  logic [31:0] sen_r;
  logic [31:0] ent_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (shift_en) begin
      vld_r <= d_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      sen_r <= d_i.sen;
      ent_r <= d_i.ent;
    end
  end

  assign q_o.vld = vld_r;
  assign q_o.sen = sen_r;
  assign q_o.ent = ent_r;

endmodule

[sv/cooccurrence_window_edge_emitter_unit.sv]
// a request is accepted in the idle state, then the scan state rotates every cell
// of the chain once past the head compare (holding while a found edge cannot be
// passed on to a stalled output), then the finish state emits the final item and
// shifts the new entry in once the output is free
// reset (rst_n low, synchronous) empties the window, clears the distance limit and
// drops any result in flight
module cooccurrence_window_edge_emitter_unit #(
  parameter int WINDOW_DEPTH      = 32,
  parameter int WEIGHT_TABLE_SIZE = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,   // distance limit
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,      // sentence_index, entity_id
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,     // source_entity, target_entity, edge_weight
  output logic [1:0]  out_tuser,     // edge_valid, window_overflowed
  output logic        out_tlast      // last_of_run
);

  localparam int IDX_W = $clog2(WINDOW_DEPTH);
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t                 state_r;
  logic [15:0]            span_limit_r;
  logic [31:0]            sen_r;
  logic [31:0]            ent_r;
  logic                   evicting_r;
  logic [IDX_W-1:0]       idx_r;
  logic [CNT_W-1:0]       cnt_r;
  cwee_pkg::edge_cnt_t    edge_cnt_r;
  logic                   pend_v_r;
  logic [31:0]            pend_src_r;
  cwee_pkg::weight_t      pend_wt_r;
  logic                   out_valid_r;
  logic [31:0]            out_src_r;
  logic [31:0]            out_tgt_r;
  cwee_pkg::weight_t      out_wt_r;
  logic                   out_edge_r;
  logic                   out_ovf_r;
  logic                   out_last_r;

  cwee_pkg::entry_t       chain_q [WINDOW_DEPTH];
  cwee_pkg::entry_t       head;
  cwee_pkg::entry_t       tail_in;
  logic [31:0]            diff;
  logic                   too_far;
  logic                   evict;
  logic                   kept;
  logic                   is_edge;
  logic                   out_free;
  logic                   stall;
  logic                   step;
  logic                   shift_en;
  logic                   load_out;
  logic                   ovf;
  cwee_pkg::weight_t      wt;

  assign head     = chain_q[0];
  assign diff     = sen_r - head.sen;
  assign too_far  = diff > {16'd0, span_limit_r};
  assign evict    = (state_r == ST_SCAN) && head.vld && evicting_r && too_far;
  assign kept     = head.vld && !evict;
  assign is_edge  = (state_r == ST_SCAN) && kept && (head.ent != ent_r)
                    && !(head.sen > sen_r)
                    && (edge_cnt_r < cwee_pkg::EDGE_CNT_W'(cwee_pkg::RESULT_LIMIT));
  assign out_free = !out_valid_r || out_tready;
  assign stall    = is_edge && pend_v_r && !out_free;
  assign step     = (state_r == ST_SCAN) && !stall;
  assign shift_en = step || ((state_r == ST_FINISH) && out_free);
  assign load_out = (step && is_edge && pend_v_r) || ((state_r == ST_FINISH) && out_free);
  assign ovf      = cnt_r == CNT_W'(WINDOW_DEPTH);
  assign wt       = (diff < 32'(WEIGHT_TABLE_SIZE)) ? cwee_pkg::WEIGHT_ROM[diff[5:0]]
                                                    : 16'd0;

  always_comb begin
    if (state_r == ST_FINISH) begin
      tail_in.vld = 1'b1;
      tail_in.sen = sen_r;
      tail_in.ent = ent_r;
    end else begin
      tail_in.vld = kept;
      tail_in.sen = head.sen;
      tail_in.ent = head.ent;
    end
  end

  // cell 0 is the oldest slot, new entries enter at the top
  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    if (i == WINDOW_DEPTH - 1) begin : g_top
      cwee_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .d_i      (tail_in),
        .q_o      (chain_q[i])
      );
    end else begin : g_mid
      cwee_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .d_i      (chain_q[i+1]),
        .q_o      (chain_q[i])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      span_limit_r <= 16'd0;
      evicting_r   <= 1'b0;
      idx_r        <= '0;
      cnt_r        <= '0;
      edge_cnt_r   <= '0;
      pend_v_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        span_limit_r <= cfg_wr_data;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            sen_r      <= in_tdata[31:0];
            ent_r      <= in_tdata[63:32];
            evicting_r <= 1'b1;
            idx_r      <= '0;
            edge_cnt_r <= '0;
            state_r    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (step) begin
            idx_r <= idx_r + 1'b1;
            if (evict) begin
              cnt_r <= cnt_r - 1'b1;
            end
            if (kept) begin
              evicting_r <= 1'b0;
            end
            if (is_edge) begin
              edge_cnt_r <= edge_cnt_r + 1'b1;
              pend_v_r   <= 1'b1;
              pend_src_r <= head.ent;
              pend_wt_r  <= wt;
              if (pend_v_r) begin
                out_src_r   <= pend_src_r;
                out_tgt_r   <= ent_r;
                out_wt_r    <= pend_wt_r;
                out_edge_r  <= 1'b1;
                out_ovf_r   <= ovf;
                out_last_r  <= 1'b0;
              end
            end
            if (idx_r == IDX_W'(WINDOW_DEPTH - 1)) begin
              state_r <= ST_FINISH;
            end
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_src_r   <= pend_v_r ? pend_src_r : 32'd0;
            out_tgt_r   <= ent_r;
            out_wt_r    <= pend_v_r ? pend_wt_r : 16'd0;
            out_edge_r  <= pend_v_r;
            out_ovf_r   <= ovf;
            out_last_r  <= 1'b1;
            pend_v_r    <= 1'b0;
            if (!ovf) begin
              cnt_r <= cnt_r + 1'b1;
            end
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_wt_r, out_tgt_r, out_src_r};
  assign out_tuser  = {out_ovf_r, out_edge_r};
  assign out_tlast  = out_last_r;

endmodule

[sv/cwee_checker.sv]
module cwee_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // one request at a time
  a_in_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while busy");

  // a marker is always the final item of its request
  a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tlast)
    else $error("marker not last");

  // marker carries no source and no weight
  a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> (out_tdata[31:0] == 32'd0)
      && (out_tdata[79:64] == 16'd0))
    else $error("marker payload not zero");

  // weight never above one
  a_weight_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[79:64] <= 16'd32768)
    else $error("weight out of range");

endmodule

bind cooccurrence_window_edge_emitter_unit cwee_checker u_cwee_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

[test/tb_cooccurrence_window_edge_emitter_unit.sv]
module tb_cooccurrence_window_edge_emitter_unit;

  localparam int WINDOW_DEPTH      = 32;
  localparam int WEIGHT_TABLE_SIZE = 16;
  localparam int DRAIN_CYCLES      = WINDOW_DEPTH + 4;
  localparam int HOLD_CYCLES       = 300;

  typedef struct packed {
    logic [31:0]       src;
    logic [31:0]       dst;
    cwee_pkg::weight_t weight;
    logic              is_edge;
    logic              ovf;
    logic              last;
  } edge_rec_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [31:0] sen;
    logic [31:0] ent;
    logic        typed;
    edge_rec_t   want;
  } row_t;

  typedef struct packed {
    int max_dist;
    int tx_pct;
    int rx_pct;
    int items;
    int noise_pct;
    bit hold_first;
    bit pause_mid;
  } phase_t;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        cfg_wr_en   = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata    = '0;   // sentence_index, entity_id
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [79:0] out_tdata;          // source_entity, target_entity, edge_weight
  logic [1:0]  out_tuser;          // edge_valid, window_overflowed
  logic        out_tlast;          // last_of_run

  // predictor copy of the window
  logic [31:0] win_sen [WINDOW_DEPTH];
  logic [31:0] win_ent [WINDOW_DEPTH];
  int unsigned win_head  = 0;
  int unsigned win_count = 0;
  logic [15:0] max_dist  = '0;

  edge_rec_t run_edges [$];
  edge_rec_t edges_due [$];
  int        mismatches   = 0;
  int        tx_idle_pct  = 0;
  int        rx_idle_pct  = 0;
  int        hold_asks    = 0;
  int        hold_taken   = 0;
  int        hold_left    = 0;

  row_t dir_rows [16] = '{
    '{ROW_ITEM, 32'd0, 32'd0, 1'b1, '{32'd0, 32'd0, 16'd0, 1'b0, 1'b0, 1'b1}},
    '{ROW_ITEM, 32'd0, 32'hFFFF_FFFF, 1'b1,
      '{32'd0, 32'hFFFF_FFFF, 16'd32768, 1'b1, 1'b0, 1'b1}},
    '{ROW_ITEM, 32'd0, 32'd0, 1'b0, '0},
    '{ROW_ITEM, 32'hFFFF_FFFF, 32'd5, 1'b1, '{32'd0, 32'd5, 16'd0, 1'b0, 1'b0, 1'b1}},
    '{ROW_ITEM, 32'd0, 32'd7, 1'b1, '{32'd0, 32'd7, 16'd0, 1'b0, 1'b0, 1'b1}},
    '{ROW_CFG, 32'd3, 32'd0, 1'b0, '0},
    '{ROW_ITEM, 32'd10, 32'd1, 1'b1, '{32'd0, 32'd1, 16'd0, 1'b0, 1'b0, 1'b1}},
    '{ROW_ITEM, 32'd11, 32'd2, 1'b1, '{32'd1, 32'd2, 16'd12055, 1'b1, 1'b0, 1'b1}},
    '{ROW_ITEM, 32'd12, 32'd1, 1'b0, '0},
    '{ROW_ITEM, 32'd11, 32'd3, 1'b0, '0},
    '{ROW_ITEM, 32'd14, 32'd4, 1'b0, '0},
    '{ROW_CFG, 32'd65535, 32'd0, 1'b0, '0},
    '{ROW_ITEM, 32'd20, 32'd9, 1'b0, '0},
    '{ROW_ITEM, 32'd40, 32'd9, 1'b0, '0},
    '{ROW_ITEM, 32'd65575, 32'd6, 1'b0, '0},
    '{ROW_CFG, 32'd0, 32'd0, 1'b0, '0}
  };

  phase_t phases [6] = '{
    '{65535, 33, 64, 80, 0, 1'b0, 1'b0},
    '{0, 33, 64, 40, 10, 1'b0, 1'b1},
    '{5, 64, 33, 80, 10, 1'b0, 1'b1},
    '{20, 64, 33, 60, 10, 1'b0, 1'b0},
    '{1, 0, 0, 60, 10, 1'b1, 1'b0},
    '{65535, 0, 0, 80, 3, 1'b1, 1'b1}
  };

  cooccurrence_window_edge_emitter_unit #(
    .WINDOW_DEPTH      (WINDOW_DEPTH),
    .WEIGHT_TABLE_SIZE (WEIGHT_TABLE_SIZE)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("tb_cooccurrence_window_edge_emitter_unit: errors");
    $finish;
  end

  // edges caused by one occurrence, window updated as the block does
  function automatic void predict_edges(input logic [31:0] sen, input logic [31:0] ent);
    int unsigned slot;
    int unsigned n = 0;
    logic        ovf;
    logic [31:0] gap;
    edge_rec_t   rec;
    run_edges.delete();
    while (win_count > 0) begin
      gap = sen - win_sen[win_head];
      if (gap <= max_dist) break;
      win_head = (win_head + 1) % WINDOW_DEPTH;
      win_count--;
    end
    ovf = (win_count >= WINDOW_DEPTH);
    for (int k = 0; k < win_count; k++) begin
      slot = (win_head + k) % WINDOW_DEPTH;
      if (win_ent[slot] != ent && win_sen[slot] <= sen && n < cwee_pkg::RESULT_LIMIT) begin
        gap = sen - win_sen[slot];
        rec = '{win_ent[slot], ent,
                (gap < WEIGHT_TABLE_SIZE && gap < cwee_pkg::WEIGHT_ROM_SIZE)
                  ? cwee_pkg::WEIGHT_ROM[gap] : 16'd0,
                1'b1, ovf, 1'b0};
        run_edges.push_back(rec);
        n++;
      end
    end
    if (win_count >= WINDOW_DEPTH) begin
      win_head  = (win_head + 1) % WINDOW_DEPTH;
      win_count = WINDOW_DEPTH - 1;
    end
    slot = (win_head + win_count) % WINDOW_DEPTH;
    win_sen[slot] = sen;
    win_ent[slot] = ent;
    win_count++;
    if (run_edges.size() == 0) run_edges.push_back('{32'd0, ent, 16'd0, 1'b0, ovf, 1'b0});
    rec = run_edges.pop_back();
    rec.last = 1'b1;
    run_edges.push_back(rec);
  endfunction

  function automatic void flag_mismatch(input string why, input edge_rec_t want,
                                        input edge_rec_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch (%s): expected src=%h dst=%h w=%0d edge=%b ovf=%b last=%b",
               why, want.src, want.dst, want.weight, want.is_edge, want.ovf, want.last);
      $display("  got src=%h dst=%h w=%0d edge=%b ovf=%b last=%b",
               got.src, got.dst, got.weight, got.is_edge, got.ovf, got.last);
    end
  endfunction

  // one request per handshake
  task automatic offer_occurrence(input logic [31:0] sen, input logic [31:0] ent,
                                  input logic typed, input edge_rec_t want);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {ent, sen};
    do @(posedge clk); while (!in_tready);
    predict_edges(sen, ent);
    if (typed) edges_due.push_back(want);
    else foreach (run_edges[i]) edges_due.push_back(run_edges[i]);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (edges_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_distance(input logic [15:0] value);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    max_dist = value;
  endtask

  task automatic random_phase(input phase_t ph);
    logic [31:0] sen_now;
    logic [31:0] ent_base;
    logic [31:0] sen;
    logic [31:0] ent;
    int          roll;
    sen_now  = ($urandom_range(1) == 1) ? 32'hFFFF_FFFF - $urandom_range(40) : $urandom();
    ent_base = $urandom();
    for (int i = 0; i < ph.items; i++) begin
      if (ph.pause_mid && i == ph.items / 2) wait_drained();
      roll = $urandom_range(99);
      ent  = ent_base + $urandom_range(7);
      if (roll < ph.noise_pct / 2) begin
        sen = $urandom();
        ent = $urandom();
      end else if (roll < ph.noise_pct) begin
        // goes back in sentence order
        sen = sen_now - $urandom_range(1, 5);
      end else if (roll < 2 * ph.noise_pct) begin
        sen_now += $urandom_range(ph.max_dist + 20);
        sen = sen_now;
      end else begin
        if ($urandom_range(1) == 1) sen_now += $urandom_range(1, 3);
        sen = sen_now;
      end
      offer_occurrence(sen, ent, 1'b0, '0);
    end
  endtask

  // receiver side, long hold-off counted here
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_taken != hold_asks) begin
      out_tready <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      hold_taken <= hold_asks;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    edge_rec_t got;
    edge_rec_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata[31:0], out_tdata[63:32], out_tdata[79:64],
              out_tuser[0], out_tuser[1], out_tlast};
      if (edges_due.size() == 0) begin
        flag_mismatch("unexpected result", '0, got);
      end else begin
        want = edges_due.pop_front();
        if (got !== want) flag_mismatch("wrong field", want, got);
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    tx_idle_pct = 33;
    rx_idle_pct = 64;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) write_max_distance(dir_rows[i].sen[15:0]);
      else offer_occurrence(dir_rows[i].sen, dir_rows[i].ent, dir_rows[i].typed,
                            dir_rows[i].want);
    end
    foreach (phases[p]) begin
      write_max_distance(phases[p].max_dist[15:0]);
      tx_idle_pct = phases[p].tx_pct;
      rx_idle_pct = phases[p].rx_pct;
      if (phases[p].hold_first) hold_asks++;
      random_phase(phases[p]);
    end
    wait_drained();
    if (edges_due.size() != 0) begin
      $display("%0d results never arrived", edges_due.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("tb_cooccurrence_window_edge_emitter_unit: clean");
    end else begin
      $display("tb_cooccurrence_window_edge_emitter_unit: errors");
    end
    $finish;
  end

endmodule

[cooccurrence_window_edge_emitter_unit.f]
sv/cwee_pkg.sv
sv/cwee_cell.sv
sv/cooccurrence_window_edge_emitter_unit.sv
sv/cwee_checker.sv
test/tb_cooccurrence_window_edge_emitter_unit.sv
